[src/array_steering_phase_rotator_core_assert.svh]
// Assertion macros for the phase rotator checker.
`ifndef ARRAY_STEERING_PHASE_ROTATOR_CORE_ASSERT_SVH
`define ARRAY_STEERING_PHASE_ROTATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ASPRC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("asprc check failed");

// Next-cycle implication, checked outside reset.
`define ASPRC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("asprc check failed");

// Implication that also holds across reset.
`define ASPRC_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("asprc check failed");

`endif

[src/asprc_pkg.sv]
// Types, constants and the quarter-wave sine builder for the phase rotator.
`timescale 1ns / 1ps
`default_nettype none
package asprc_pkg;

   localparam int TRIG_BITS   = 12;
   localparam int QUARTER     = 1024;
   localparam int TRIG_W      = 16;
   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int ANT_CNT_W   = 5;
   localparam int MAX_RESULTS = 64;
   localparam int ACC_W       = 56;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   localparam logic CMD_SAMPLE      = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   localparam logic [2:0] REG_NUM_ANT_X   = 3'd0;
   localparam logic [2:0] REG_NUM_ANT_Y   = 3'd1;
   localparam logic [2:0] REG_PHASE_MODE  = 3'd2;
   localparam logic [2:0] REG_SPACING_X   = 3'd3;
   localparam logic [2:0] REG_SPACING_Y   = 3'd4;
   localparam logic [2:0] REG_STEER_THETA = 3'd5;
   localparam logic [2:0] REG_STEER_PHI   = 3'd6;

   typedef logic [14:0] qtab_type [0:QUARTER];

   typedef struct packed {
      logic [3:0]  num_ant_x;
      logic [3:0]  num_ant_y;
      logic        phase_mode;
      logic [15:0] spacing_x;
      logic [15:0] spacing_y;
      logic [15:0] steer_theta;
      logic [15:0] steer_phi;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic twrite;
      logic trig_a;
      logic trig_b;
      logic prod;
      logic scale;
      logic phase;
      logic lookup;
      logic mult;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_ant;
   } stat_type;

   // Taylor series for sin over the first quarter turn, Q30 fixed point.
   function automatic qtab_type build_quarter();
      qtab_type    tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      for (int j = 0; j <= QUARTER; j++) begin
         x    = (64'(j) * TWO_PI_Q30) >> TRIG_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tab[j] = v[14:0];
      end
      return tab;
   endfunction

endpackage
`default_nettype wire

[src/asprc_sine_rom.sv]
// Dual-port sine ROM, quarter-wave folded, registered read.
`timescale 1ns / 1ps
`default_nettype none
module asprc_sine_rom (
   input  wire logic                              clock,
   input  wire logic [asprc_pkg::TRIG_BITS-1:0]   addr_a,
   input  wire logic [asprc_pkg::TRIG_BITS-1:0]   addr_b,
   output logic signed [asprc_pkg::TRIG_W-1:0]    data_a,
   output logic signed [asprc_pkg::TRIG_W-1:0]    data_b
);

   localparam asprc_pkg::qtab_type QTAB = asprc_pkg::build_quarter();

   logic [10:0] qa;
   logic [10:0] qb;
   logic signed [asprc_pkg::TRIG_W-1:0] sa;
   logic signed [asprc_pkg::TRIG_W-1:0] sb;
   logic signed [asprc_pkg::TRIG_W-1:0] data_a_ff;
   logic signed [asprc_pkg::TRIG_W-1:0] data_b_ff;

   always_comb begin
      qa = addr_a[10] ? (11'd1024 - {1'b0, addr_a[9:0]}) : {1'b0, addr_a[9:0]};
      qb = addr_b[10] ? (11'd1024 - {1'b0, addr_b[9:0]}) : {1'b0, addr_b[9:0]};
      sa = addr_a[11] ? -$signed({1'b0, QTAB[qa]}) : $signed({1'b0, QTAB[qa]});
      sb = addr_b[11] ? -$signed({1'b0, QTAB[qb]}) : $signed({1'b0, QTAB[qb]});
   end

   always_ff @(posedge clock) begin
      data_a_ff <= sa;
      data_b_ff <= sb;
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule
`default_nettype wire

[src/asprc_datapath.sv]
// Datapath: angle products, per-antenna phase, table, rotation, output register.
`timescale 1ns / 1ps
`default_nettype none
module asprc_datapath #(
   parameter int MAX_ANT_X    = 8,
   parameter int MAX_ANT_Y    = 8,
   parameter int SAMPLE_WIDTH = 16,
   parameter int ANGLE_WIDTH  = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire asprc_pkg::cmd_type                    cmd,
   output asprc_pkg::stat_type                        stat,
   input  wire asprc_pkg::cfg_type                    cfg,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_i,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_q,
   input  wire logic                                  req_theta_present,
   input  wire logic [ANGLE_WIDTH-1:0]                req_theta_in,
   input  wire logic                                  req_phi_present,
   input  wire logic [ANGLE_WIDTH-1:0]                req_phi_in,
   input  wire logic [asprc_pkg::INDEX_W-1:0]         req_table_index,
   input  wire logic [ANGLE_WIDTH-1:0]                req_table_phase,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic [asprc_pkg::INDEX_W-1:0]              rsp_antenna_index,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_out_q,
   output logic [ANGLE_WIDTH-1:0]                     rsp_phase_turns,
   output logic                                       rsp_last
);

   localparam int TB     = asprc_pkg::TRIG_BITS;
   localparam int TW     = asprc_pkg::TRIG_W;
   localparam int AW     = asprc_pkg::ACC_W;
   localparam int CW     = asprc_pkg::COUNT_W;
   localparam int NW     = asprc_pkg::ANT_CNT_W;
   localparam int PH_LSB = 42 - ANGLE_WIDTH;
   localparam int PW     = SAMPLE_WIDTH + TW;
   localparam int RW     = PW + 2;
   localparam logic signed [AW-1:0] PH_RND = AW'(64'd1 << (PH_LSB - 1));
   localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
   localparam logic [NW-1:0] NX_MAX = NW'(MAX_ANT_X);
   localparam logic [NW-1:0] NY_MAX = NW'(MAX_ANT_Y);

   // sample latch
   logic signed [SAMPLE_WIDTH-1:0] si_ff, sq_ff;
   logic [ANGLE_WIDTH-1:0] theta_ff, phi_ff;
   logic [NW-1:0] nx_ff, nx_in, ny_in;
   logic [CW-1:0] total_ff, total_in;
   logic [2*NW-1:0] total_full;

   // angle terms
   logic signed [TW-1:0] sin_t_ff, cos_p_ff;
   logic signed [2*TW-1:0] sx_ff, sy_ff;
   logic signed [AW-1:0] ax_ff, ay_ff;
   logic signed [48:0] ax_prod, ay_prod;

   // antenna walk
   logic signed [AW-1:0] acc_ff, acc_row_ff, acc_rnd;
   logic [NW-1:0] kx_ff;
   logic [CW-1:0] count_ff;
   logic [ANGLE_WIDTH-1:0] ph_calc_ff, ph_ff, ph_sel;

   // phase table
   logic [ANGLE_WIDTH-1:0] tab_mem [asprc_pkg::TABLE_DEPTH];
   logic [asprc_pkg::TABLE_DEPTH-1:0] tab_vld_ff;
   logic [ANGLE_WIDTH-1:0] tab_rd_ff;
   logic tab_rd_vld_ff;

   // trig ROM
   logic [TB-1:0] rom_a, rom_b;
   logic signed [TW-1:0] rom_da, rom_db;

   // rotation
   logic signed [PW-1:0] p_ic_ff, p_qs_ff, p_is_ff, p_qc_ff;
   logic signed [PW:0] sum_i, sum_q;
   logic signed [RW-1:0] rnd_i, rnd_q, sat_i, sat_q;

   // output register
   logic out_valid_ff;
   logic [asprc_pkg::INDEX_W-1:0] out_idx_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_i_ff, out_q_ff;
   logic [ANGLE_WIDTH-1:0] out_ph_ff;
   logic out_last_ff;

   asprc_sine_rom u_rom (
      .clock  (clock),
      .addr_a (rom_a),
      .addr_b (rom_b),
      .data_a (rom_da),
      .data_b (rom_db)
   );

   // effective array size; zero acts as one, clamp to the build maximum
   always_comb begin
      nx_in = {1'b0, cfg.num_ant_x};
      ny_in = {1'b0, cfg.num_ant_y};
      if (nx_in == '0) nx_in = NW'(1);
      if (ny_in == '0) ny_in = NW'(1);
      if (nx_in > NX_MAX) nx_in = NX_MAX;
      if (ny_in > NY_MAX) ny_in = NY_MAX;
      total_full = nx_in * ny_in;
      total_in   = (total_full > (2*NW)'(asprc_pkg::MAX_RESULTS)) ?
                   CW'(asprc_pkg::MAX_RESULTS) : total_full[CW-1:0];
   end

   always_comb begin
      ph_sel = cfg.phase_mode ? (tab_rd_vld_ff ? tab_rd_ff : '0) : ph_calc_ff;
      rom_a  = '0;
      rom_b  = '0;
      if (cmd.trig_a) begin
         rom_a = theta_ff[ANGLE_WIDTH-1 -: TB];
         rom_b = phi_ff[ANGLE_WIDTH-1 -: TB] + TB'(asprc_pkg::QUARTER);
      end else if (cmd.trig_b) begin
         rom_b = phi_ff[ANGLE_WIDTH-1 -: TB];
      end else if (cmd.lookup) begin
         rom_a = ph_sel[ANGLE_WIDTH-1 -: TB];
         rom_b = ph_sel[ANGLE_WIDTH-1 -: TB] + TB'(asprc_pkg::QUARTER);
      end
   end

   assign ax_prod = $signed({1'b0, cfg.spacing_x}) * sx_ff;
   assign ay_prod = $signed({1'b0, cfg.spacing_y}) * sy_ff;
   assign acc_rnd = acc_ff + PH_RND;

   assign sum_i = p_ic_ff - p_qs_ff;
   assign sum_q = p_is_ff + p_qc_ff;
   assign rnd_i = (sum_i + 16384) >>> 15;
   assign rnd_q = (sum_q + 16384) >>> 15;
   assign sat_i = (rnd_i > SAT_HI) ? SAT_HI : ((rnd_i < SAT_LO) ? SAT_LO : rnd_i);
   assign sat_q = (rnd_q > SAT_HI) ? SAT_HI : ((rnd_q < SAT_LO) ? SAT_LO : rnd_q);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         si_ff    <= req_sample_i;
         sq_ff    <= req_sample_q;
         theta_ff <= req_theta_present ? req_theta_in : ANGLE_WIDTH'(cfg.steer_theta);
         phi_ff   <= req_phi_present ? req_phi_in : ANGLE_WIDTH'(cfg.steer_phi);
         nx_ff    <= nx_in;
         total_ff <= total_in;
      end
      if (cmd.trig_b) begin
         sin_t_ff <= rom_da;
         cos_p_ff <= rom_db;
      end
      if (cmd.prod) begin
         sx_ff <= sin_t_ff * cos_p_ff;
         sy_ff <= sin_t_ff * rom_db;
      end
      if (cmd.scale) begin
         ax_ff      <= AW'(ax_prod);
         ay_ff      <= AW'(ay_prod);
         acc_ff     <= '0;
         acc_row_ff <= '0;
         kx_ff      <= '0;
         count_ff   <= '0;
      end
      if (cmd.phase) begin
         ph_calc_ff    <= acc_rnd[PH_LSB +: ANGLE_WIDTH];
         tab_rd_ff     <= tab_mem[count_ff[asprc_pkg::INDEX_W-1:0]];
         tab_rd_vld_ff <= tab_vld_ff[count_ff[asprc_pkg::INDEX_W-1:0]];
      end
      if (cmd.lookup) begin
         ph_ff <= ph_sel;
      end
      if (cmd.mult) begin
         p_ic_ff <= si_ff * rom_db;
         p_qs_ff <= sq_ff * rom_da;
         p_is_ff <= si_ff * rom_da;
         p_qc_ff <= sq_ff * rom_db;
      end
      if (cmd.emit) begin
         out_idx_ff  <= count_ff[asprc_pkg::INDEX_W-1:0];
         out_i_ff    <= sat_i[SAMPLE_WIDTH-1:0];
         out_q_ff    <= sat_q[SAMPLE_WIDTH-1:0];
         out_ph_ff   <= ph_ff;
         out_last_ff <= stat.last_ant;
         count_ff    <= count_ff + CW'(1);
         // step along the row, or wrap to the start of the next row
         if (kx_ff + NW'(1) == nx_ff) begin
            kx_ff      <= '0;
            acc_row_ff <= acc_row_ff + ay_ff;
            acc_ff     <= acc_row_ff + ay_ff;
         end else begin
            kx_ff  <= kx_ff + NW'(1);
            acc_ff <= acc_ff + ax_ff;
         end
      end
      if (cmd.twrite) begin
         tab_mem[req_table_index] <= req_table_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_vld_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.twrite) begin
            tab_vld_ff[req_table_index] <= 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free = !out_valid_ff || rsp_ready;
   assign stat.last_ant = (count_ff + CW'(1)) == total_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_antenna_index = out_idx_ff;
   assign rsp_out_i         = out_i_ff;
   assign rsp_out_q         = out_q_ff;
   assign rsp_phase_turns   = out_ph_ff;
   assign rsp_last          = out_last_ff;

endmodule
`default_nettype wire

[src/asprc_ctrl.sv]
// Controller: sequences angle setup and the per-antenna steps.
`timescale 1ns / 1ps
`default_nettype none
module asprc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_command,
   output logic                      req_ready,
   input  wire asprc_pkg::stat_type  stat,
   output asprc_pkg::cmd_type        cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TRIG_A = 4'd1;
   localparam logic [3:0] ST_TRIG_B = 4'd2;
   localparam logic [3:0] ST_PROD   = 4'd3;
   localparam logic [3:0] ST_SCALE  = 4'd4;
   localparam logic [3:0] ST_PHASE  = 4'd5;
   localparam logic [3:0] ST_LOOKUP = 4'd6;
   localparam logic [3:0] ST_MULT   = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.load   = req_valid && (req_command == asprc_pkg::CMD_SAMPLE);
            cmd.twrite = req_valid && (req_command == asprc_pkg::CMD_TABLE_WRITE);
            if (cmd.load) state_in = ST_TRIG_A;
         end
         ST_TRIG_A: begin
            cmd.trig_a = 1'b1;
            state_in   = ST_TRIG_B;
         end
         ST_TRIG_B: begin
            cmd.trig_b = 1'b1;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_PHASE;
         end
         ST_PHASE: begin
            cmd.phase = 1'b1;
            state_in  = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.last_ant ? ST_IDLE : ST_PHASE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[src/array_steering_phase_rotator_core.sv]
// Planar-array beam-steering phase rotator, top level with register file.
`timescale 1ns / 1ps
`default_nettype none
// A sample request fans out to one result per antenna of an nx-by-ny array,
// row-major, each carrying the antenna phase (1/65536 turn) and the sample
// rotated by it. A table-write request loads one per-antenna phase and returns
// nothing. A sample is taken in an idle cycle, then goes through angle setup
// (TRIG_A, TRIG_B, PROD, SCALE) through the shared two-port sine ROM, then
// per antenna through phase, ROM lookup, multiply, and round and saturate;
// the next request is taken once the last antenna is emitted, and each emit
// waits on rsp_ready while the output register still holds a result. The output
// register lets the next antenna be formed while a result waits on rsp_ready.
// No clearing pass is needed after reset; the phase table uses per-entry valid
// bits.
module array_steering_phase_rotator_core #(
   parameter int MAX_ANT_X    = 8,
   parameter int MAX_ANT_Y    = 8,
   parameter int SAMPLE_WIDTH = 16,
   parameter int ANGLE_WIDTH  = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_command,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_sample_i,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_sample_q,
   input  wire logic                                   req_theta_present,
   input  wire logic [ANGLE_WIDTH-1:0]                 req_theta_in,
   input  wire logic                                   req_phi_present,
   input  wire logic [ANGLE_WIDTH-1:0]                 req_phi_in,
   input  wire logic [asprc_pkg::INDEX_W-1:0]          req_table_index,
   input  wire logic [ANGLE_WIDTH-1:0]                 req_table_phase,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [asprc_pkg::INDEX_W-1:0]               rsp_antenna_index,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_out_q,
   output logic [ANGLE_WIDTH-1:0]                      rsp_phase_turns,
   output logic                                        rsp_last,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [asprc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [asprc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [asprc_pkg::CSR_DATA_W-1:0]            prdata,
   output logic                                        pready
);

   asprc_pkg::cfg_type  cfg_ff;
   asprc_pkg::cmd_type  cmd;
   asprc_pkg::stat_type stat;
   logic [2:0] reg_idx;
   logic       csr_wr;

   assign reg_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_ant_x   <= 4'd4;
         cfg_ff.num_ant_y   <= 4'd4;
         cfg_ff.phase_mode  <= 1'b0;
         cfg_ff.spacing_x   <= 16'd2048;
         cfg_ff.spacing_y   <= 16'd2048;
         cfg_ff.steer_theta <= 16'd0;
         cfg_ff.steer_phi   <= 16'd0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            asprc_pkg::REG_NUM_ANT_X:   cfg_ff.num_ant_x   <= pwdata[3:0];
            asprc_pkg::REG_NUM_ANT_Y:   cfg_ff.num_ant_y   <= pwdata[3:0];
            asprc_pkg::REG_PHASE_MODE:  cfg_ff.phase_mode  <= pwdata[0];
            asprc_pkg::REG_SPACING_X:   cfg_ff.spacing_x   <= pwdata[15:0];
            asprc_pkg::REG_SPACING_Y:   cfg_ff.spacing_y   <= pwdata[15:0];
            asprc_pkg::REG_STEER_THETA: cfg_ff.steer_theta <= pwdata[15:0];
            asprc_pkg::REG_STEER_PHI:   cfg_ff.steer_phi   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         asprc_pkg::REG_NUM_ANT_X:   prdata = 32'(cfg_ff.num_ant_x);
         asprc_pkg::REG_NUM_ANT_Y:   prdata = 32'(cfg_ff.num_ant_y);
         asprc_pkg::REG_PHASE_MODE:  prdata = 32'(cfg_ff.phase_mode);
         asprc_pkg::REG_SPACING_X:   prdata = 32'(cfg_ff.spacing_x);
         asprc_pkg::REG_SPACING_Y:   prdata = 32'(cfg_ff.spacing_y);
         asprc_pkg::REG_STEER_THETA: prdata = 32'(cfg_ff.steer_theta);
         asprc_pkg::REG_STEER_PHI:   prdata = 32'(cfg_ff.steer_phi);
         default:                    prdata = '0;
      endcase
   end

   asprc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   asprc_datapath #(
      .MAX_ANT_X    (MAX_ANT_X),
      .MAX_ANT_Y    (MAX_ANT_Y),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .cfg               (cfg_ff),
      .req_sample_i      (req_sample_i),
      .req_sample_q      (req_sample_q),
      .req_theta_present (req_theta_present),
      .req_theta_in      (req_theta_in),
      .req_phi_present   (req_phi_present),
      .req_phi_in        (req_phi_in),
      .req_table_index   (req_table_index),
      .req_table_phase   (req_table_phase),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_antenna_index (rsp_antenna_index),
      .rsp_out_i         (rsp_out_i),
      .rsp_out_q         (rsp_out_q),
      .rsp_phase_turns   (rsp_phase_turns),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

[src/asprc_checker.sv]
// Port-level checker for the phase rotator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "array_steering_phase_rotator_core_assert.svh"
module asprc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_command,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_last,
   input wire logic [5:0] rsp_antenna_index
);

   // no result survives reset
   `ASPRC_ASSERT_ALWAYS(a_reset_empty, $past(reset), !rsp_valid)

   // an accepted sample request takes the block out of idle, so req_ready drops
   `ASPRC_ASSERT_NEXT(a_sample_busy, req_valid && req_ready && !req_command, !req_ready)

   // while a non-final antenna is handed over, the sample is still in work
   `ASPRC_ASSERT_NOW(a_mid_busy, rsp_valid && rsp_ready && !rsp_last, !req_ready)

   // a stalled result holds
   `ASPRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                      rsp_valid && $stable(rsp_antenna_index) && $stable(rsp_last))

endmodule

bind array_steering_phase_rotator_core asprc_checker u_asprc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_last          (rsp_last),
   .rsp_antenna_index (rsp_antenna_index)
);
`default_nettype wire

[test/array_steering_phase_rotator_core_test.sv]
// Self-checking testbench for the planar-array phase rotator core.
`timescale 1ns / 1ps
module array_steering_phase_rotator_core_test;

   typedef struct {
      logic [5:0]         ant;
      logic signed [15:0] oi;
      logic signed [15:0] oq;
      logic [15:0]        ph;
      logic               last;
   } antenna_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = asprc_pkg::CMD_SAMPLE;
   logic signed [15:0] req_sample_i = '0;
   logic signed [15:0] req_sample_q = '0;
   logic req_theta_present = 1'b0;
   logic [15:0] req_theta_in = '0;
   logic req_phi_present = 1'b0;
   logic [15:0] req_phi_in = '0;
   logic [5:0] req_table_index = '0;
   logic [15:0] req_table_phase = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_antenna_index;
   logic signed [15:0] rsp_out_i;
   logic signed [15:0] rsp_out_q;
   logic [15:0] rsp_phase_turns;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [asprc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [asprc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [asprc_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   array_steering_phase_rotator_core dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int unsigned sine_lut [0:4095];
   logic [15:0] phase_table [0:63];
   logic [3:0]  ant_x_cfg = 4, ant_y_cfg = 4;
   logic        table_mode_cfg = 0;
   logic [15:0] pitch_x_cfg = 2048, pitch_y_cfg = 2048;
   logic [15:0] theta_cfg = 0, phi_cfg = 0;

   antenna_result_type pending_results[$];
   int  errors = 0;
   int  burst_left = 0;
   bit  stall_req = 0;
   int  stall_cnt = 0;

   function automatic int quarter_wave(int j);
      logic [63:0] x, x2, term, v;
      longint sum;
      x = (64'(j) * 64'd6746518852) >> 12;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return int'(v);
   endfunction

   function automatic longint sin_turns(logic [15:0] a);
      return longint'(int'(sine_lut[a[15:4]]));
   endfunction

   function automatic longint cos_turns(logic [15:0] a);
      logic [11:0] i;
      i = a[15:4] + 12'd1024;
      return longint'(int'(sine_lut[i]));
   endfunction

   function automatic logic signed [15:0] round_sat(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Expected per-antenna results of one accepted sample request.
   task automatic predict_rotation();
      int nx, ny, total, n;
      logic [15:0] th, ph_a, ph;
      longint sx, sy, acc, c, s, si, sq;
      logic [63:0] u;
      antenna_result_type r;
      nx = (ant_x_cfg == 0) ? 1 : (ant_x_cfg > 8) ? 8 : ant_x_cfg;
      ny = (ant_y_cfg == 0) ? 1 : (ant_y_cfg > 8) ? 8 : ant_y_cfg;
      total = nx * ny;
      n = 0;
      si = req_sample_i;
      sq = req_sample_q;
      th = req_theta_present ? req_theta_in : theta_cfg;
      ph_a = req_phi_present ? req_phi_in : phi_cfg;
      sx = sin_turns(th) * cos_turns(ph_a);
      sy = sin_turns(th) * sin_turns(ph_a);
      for (int ky = 0; ky < ny; ky++) begin
         for (int kx = 0; kx < nx; kx++) begin
            r.ant = 6'(ky * nx + kx);
            if (table_mode_cfg) begin
               ph = phase_table[r.ant];
            end else begin
               acc = longint'(kx * pitch_x_cfg) * sx + longint'(ky * pitch_y_cfg) * sy;
               u = 64'(acc) + (64'd1 << 25);
               ph = u[41:26];
            end
            c = cos_turns(ph);
            s = sin_turns(ph);
            r.oi = round_sat(si * c - sq * s);
            r.oq = round_sat(si * s + sq * c);
            r.ph = ph;
            n++;
            r.last = (n == total);
            pending_results.insert(pending_results.size(), r);
         end
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      antenna_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result ant=%0d i=%0d q=%0d ph=%0d last=%0b", $time,
                     rsp_antenna_index, rsp_out_i, rsp_out_q, rsp_phase_turns, rsp_last);
            errors++;
         end else begin
            e = pending_results[0];
            pending_results.delete(0);
            if (rsp_antenna_index !== e.ant || rsp_out_i !== e.oi || rsp_out_q !== e.oq ||
                rsp_phase_turns !== e.ph || rsp_last !== e.last) begin
               $display("%0t: mismatch expected ant=%0d i=%0d q=%0d ph=%0d last=%0b", $time,
                        e.ant, e.oi, e.oq, e.ph, e.last);
               $display("%0t:          actual   ant=%0d i=%0d q=%0d ph=%0d last=%0b", $time,
                        rsp_antenna_index, rsp_out_i, rsp_out_q, rsp_phase_turns, rsp_last);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern, plus a long hold when requested
   always @(negedge clock) begin
      if (stall_req && stall_cnt < 600) begin
         stall_cnt <= stall_cnt + 1;
         rsp_ready <= 1'b0;
      end else begin
         if (!stall_req) stall_cnt <= 0;
         case ($urandom_range(0, 3))
            0: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic send_request(logic cmd, logic [15:0] si, logic [15:0] sq,
                               logic tp, logic [15:0] ti, logic pp, logic [15:0] pi,
                               logic [5:0] idx, logic [15:0] tph);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sample_i <= si;
      req_sample_q <= sq;
      req_theta_present <= tp;
      req_theta_in <= ti;
      req_phi_present <= pp;
      req_phi_in <= pi;
      req_table_index <= idx;
      req_table_phase <= tph;
      do @(posedge clock); while (!req_ready);
      if (cmd == asprc_pkg::CMD_TABLE_WRITE) phase_table[idx] = tph;
      else predict_rotation();
      burst_left--;
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_random();
      logic [15:0] si, sq;
      si = 16'($urandom);
      sq = 16'($urandom);
      if ($urandom_range(0, 9) == 0) si = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      if ($urandom_range(0, 9) == 0) sq = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      send_request(($urandom_range(0, 3) == 0) ? asprc_pkg::CMD_TABLE_WRITE :
                   asprc_pkg::CMD_SAMPLE, si, sq,
                   1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)),
                   16'($urandom), 6'($urandom), 16'($urandom));
   endtask

   task automatic wait_drained();
      if (req_valid) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] reg_id, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= asprc_pkg::CSR_ADDR_W'({reg_id, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_id)
         asprc_pkg::REG_NUM_ANT_X:   ant_x_cfg = value[3:0];
         asprc_pkg::REG_NUM_ANT_Y:   ant_y_cfg = value[3:0];
         asprc_pkg::REG_PHASE_MODE:  table_mode_cfg = value[0];
         asprc_pkg::REG_SPACING_X:   pitch_x_cfg = value[15:0];
         asprc_pkg::REG_SPACING_Y:   pitch_y_cfg = value[15:0];
         asprc_pkg::REG_STEER_THETA: theta_cfg = value[15:0];
         asprc_pkg::REG_STEER_PHI:   phi_cfg = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic apply_array(int nx, int ny, int mode, int dx, int dy, int th, int ph);
      csr_write(asprc_pkg::REG_NUM_ANT_X, nx);
      csr_write(asprc_pkg::REG_NUM_ANT_Y, ny);
      csr_write(asprc_pkg::REG_PHASE_MODE, mode);
      csr_write(asprc_pkg::REG_SPACING_X, dx);
      csr_write(asprc_pkg::REG_SPACING_Y, dy);
      csr_write(asprc_pkg::REG_STEER_THETA, th);
      csr_write(asprc_pkg::REG_STEER_PHI, ph);
   endtask

   task automatic test_reset_defaults();
      send_request(asprc_pkg::CMD_SAMPLE, 16'h7fff, 16'h0000, 0, 0, 0, 0, 0, 0);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h1234, 16'hedcb, 1, 16'h1000, 1, 16'h2000,
                   0, 0);
      wait_drained();
   endtask

   task automatic test_angle_extremes();
      apply_array(8, 8, 0, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h7fff, 16'h7fff, 1, 16'h4000, 1, 16'h0000,
                   0, 0);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 1, 16'hffff, 1, 16'hffff,
                   0, 0);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h8000, 16'h7fff, 1, 16'h3fff, 1, 16'h6000,
                   0, 0);
      wait_drained();
      apply_array(0, 15, 0, 0, 16'h1000, 16'h2000, 16'h4000);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0, 0);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 0, 16'hffff, 1, 16'h8000,
                   0, 0);
      wait_drained();
      apply_array(15, 0, 0, 16'h0800, 0, 16'h1800, 16'hc000);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h4000, 16'hc000, 0, 0, 0, 0, 0, 0);
      wait_drained();
      apply_array(1, 1, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_phase_table();
      apply_array(8, 8, 1, 2048, 2048, 0, 0);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0, 0);
      send_request(asprc_pkg::CMD_TABLE_WRITE, 16'hffff, 16'hffff, 1, 16'hffff, 1, 16'hffff,
                   0, 16'hffff);
      send_request(asprc_pkg::CMD_TABLE_WRITE, 0, 0, 0, 0, 0, 0, 6'd63, 16'h8000);
      send_request(asprc_pkg::CMD_TABLE_WRITE, 0, 0, 0, 0, 0, 0, 6'd9, 16'h4000);
      send_request(asprc_pkg::CMD_TABLE_WRITE, 0, 0, 0, 0, 0, 0, 6'd10, 16'h0000);
      send_request(asprc_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 1, 16'h1111, 0, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_random_arrays();
      for (int p = 0; p < 12; p++) begin
         if ($urandom_range(0, 2) == 0)
            apply_array($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1),
                        $urandom, $urandom, $urandom, $urandom);
         else
            apply_array($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 1),
                        $urandom, $urandom, $urandom, $urandom);
         repeat (28) send_random();
         wait_drained();
      end
   endtask

   task automatic test_output_backpressure();
      apply_array(3, 2, 0, 16'h0c00, 16'h1800, 16'h1000, 16'h3000);
      stall_req = 1;
      repeat (8) send_random();
      wait_drained();
      stall_req = 0;
      repeat (10) send_random();
      wait_drained();
   endtask

   initial begin
      for (int j = 0; j < 4096; j++) begin
         int q, r;
         r = j % 1024;
         q = ((j / 1024) % 2 == 1) ? quarter_wave(1024 - r) : quarter_wave(r);
         sine_lut[j] = ((j / 1024) >= 2) ? -q : q;
      end
      for (int k = 0; k < 64; k++) phase_table[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_angle_extremes();
      test_phase_table();
      test_output_backpressure();
      test_random_arrays();
      wait_drained();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
